### rtl/core/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

  localparam int MAX_TAPS       = 32;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int OUT_W          = 32;
  localparam int CNT_W          = 16;
  localparam int CFG_W          = 6;
  localparam int WIN            = 2 * MAX_TAPS + 1;
  localparam int HEAD           = MAX_TAPS + 1;
  localparam int MAX_RESULTS    = MAX_TAPS + 1;
  localparam int WIN_AW         = $clog2(WIN);
  localparam int HEAD_AW        = $clog2(HEAD);
  localparam int TAP_AW         = $clog2(MAX_TAPS);
  localparam int RES_W          = $clog2(MAX_RESULTS + 1);
  // signed position / offset arithmetic
  localparam int POS_W          = CNT_W + 3;
  localparam int EXT_W          = SAMPLE_BITS + 2;
  localparam int PAIR_W         = SAMPLE_BITS + 3;
  localparam int PROD_W         = COEF_BITS + PAIR_W;
  localparam int ACC_W          = PROD_W + TAP_AW + 1;
  localparam int SH_W           = ACC_W - COEF_FRAC_BITS;

  // register indexes
  localparam logic [1:0] CFG_HALF_TAPS     = 2'd0;
  localparam logic [1:0] CFG_ODD_LENGTH    = 2'd1;
  localparam logic [1:0] CFG_DIFFERENTIATE = 2'd2;
  localparam logic [1:0] CFG_EDGE_HOLD     = 2'd3;

  // item opcodes
  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                          op;
    logic [4:0]                    coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    saturated;
    logic                    end_of_record;
  } result_t;

  typedef struct packed {
    logic clear;
    logic pair_en;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

endpackage
`default_nettype wire

### rtl/core/sfd_ram.sv
`default_nettype none
module sfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/sfd_mac.sv
`default_nettype none
module sfd_mac
  import sfd_pkg::*;
(
  input  wire logic                          clk,
  input  wire mac_ctl_t                      ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] ra1,
  input  wire logic signed [SAMPLE_BITS-1:0] rb1,
  input  wire logic signed [SAMPLE_BITS-1:0] ra2,
  input  wire logic signed [SAMPLE_BITS-1:0] rb2,
  input  wire logic                          refl1,
  input  wire logic                          refl2,
  input  wire logic                          use2,
  input  wire logic                          sub,
  input  wire logic signed [COEF_BITS-1:0]   coef,
  output logic signed [OUT_W-1:0]            value,
  output logic                               saturated
);

  logic signed [EXT_W-1:0]  e1, e2;
  logic signed [PAIR_W-1:0] t2, pair_next;
  logic signed [PAIR_W-1:0] pair;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SH_W-1:0]   sh;
  logic                     ovf;

  // extended samples: plain or point-reflected (2*edge - mirror)
  always_comb begin
    e1 = refl1 ? (EXT_W'(ra1) <<< 1) - EXT_W'(rb1) : EXT_W'(ra1);
    e2 = refl2 ? (EXT_W'(ra2) <<< 1) - EXT_W'(rb2) : EXT_W'(ra2);
    t2 = use2 ? PAIR_W'(e2) : '0;
    pair_next = sub ? PAIR_W'(e1) - t2 : PAIR_W'(e1) + t2;
  end

  always_ff @(posedge clk) begin
    if (ctl.pair_en) begin
      pair <= pair_next;
    end
    if (ctl.mul_en) begin
      prod <= PROD_W'(coef) * PROD_W'(pair);
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // floor shift and saturation to the output range
  always_comb begin
    sh  = SH_W'(acc >>> COEF_FRAC_BITS);
    ovf = !((&sh[SH_W-1:OUT_W-1]) || !(|sh[SH_W-1:OUT_W-1]));
    saturated = ovf;
    if (!ovf) begin
      value = sh[OUT_W-1:0];
    end else if (sh[SH_W-1]) begin
      value = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      value = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

### rtl/core/symmetric_fir_differentiator.sv
`default_nettype none
// The block takes one word at a time and stalls new words until it is back in idle;
// each tap costs four registered sample-memory reads, a pre-add, one multiply and one
// accumulate on the single shared MAC unit.
// Reset (rst, synchronous): registers 1,1,0,0, seen and done counters and window pointer cleared;
// sample and coefficient memories keep their contents.
module symmetric_fir_differentiator
  import sfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire item_t            item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output result_t               result
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_ADDR, S_WAIT, S_PAIR, S_MUL, S_ACC, S_EMIT
  } state_t;

  typedef enum logic [1:0] { SEL_WIN, SEL_HEAD, SEL_ZERO } sel_t;

  state_t state;
  logic [CFG_W-1:0] half_taps;
  logic odd_length, differentiate, edge_hold;

  logic signed [COEF_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] raw [4];
  logic [CNT_W-1:0] seen, done, pend, b;
  logic [WIN_AW-1:0] wr_pos;
  logic wrapped, last_q;
  logic [RES_W-1:0] cnt;
  logic [TAP_AW-1:0] j;
  logic [1:0] rd;
  logic refl1, refl2;
  sel_t sel;

  logic accept, out_free, sample_acc, emit;
  logic [CNT_W-1:0] seen_next;
  logic [CFG_W-1:0] n;
  logic [CFG_W-1:0] look;
  logic [TAP_AW-1:0] ci;
  logic signed [POS_W-1:0] s_pos, r, dp, dm, ra, rb, back, a, t;
  logic left, right, refl;
  logic [WIN_AW-1:0] win_raddr;
  logic [HEAD_AW-1:0] head_raddr;
  sel_t sel_next;
  logic [SAMPLE_BITS-1:0] win_rdata, head_rdata;
  mac_ctl_t ctl;
  logic signed [OUT_W-1:0] mac_value;
  logic mac_sat;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign sample_acc = accept && (item.op == OP_SAMPLE);
  assign out_free   = !result_valid || !result_stall;
  assign emit       = (state == S_EMIT) && out_free;
  assign seen_next  = seen + 1'b1;

  // taps in use, clamped, and lookahead
  always_comb begin
    if (half_taps == '0) begin
      n = CFG_W'(1);
    end else if (half_taps > CFG_W'(MAX_TAPS)) begin
      n = CFG_W'(MAX_TAPS);
    end else begin
      n = half_taps;
    end
    look = (differentiate || !odd_length) ? n : n - 1'b1;
    ci   = TAP_AW'(n - 1'b1 - CFG_W'(j));
  end

  // tap offset to a back distance, then edge extension
  always_comb begin
    s_pos = POS_W'(seen - 1'b1);
    dp = (differentiate || !odd_length) ? POS_W'(j) + POS_W'(1) : POS_W'(j);
    dm = differentiate ? POS_W'(j) + POS_W'(1) : POS_W'(j);
    r  = rd[1] ? POS_W'(b) + dm : POS_W'(b) - dp;
    right = (r < 0);
    left  = !wrapped && (r > s_pos);
    refl  = (left || right) && !edge_hold;
    ra = r;
    rb = r;
    if (right) begin
      ra = '0;
      rb = (!wrapped && (-r > s_pos)) ? s_pos : -r;
    end else if (left) begin
      ra = s_pos;
      rb = (s_pos + s_pos - r < 0) ? '0 : s_pos + s_pos - r;
    end
    back = rd[0] ? rb : ra;
    a = s_pos - back;
    t = POS_W'(wr_pos) + POS_W'(WIN - 1) - back;
    if (t >= POS_W'(WIN)) begin
      t = t - POS_W'(WIN);
    end
    win_raddr  = WIN_AW'(t);
    head_raddr = HEAD_AW'(a);
    if (back < POS_W'(WIN)) begin
      sel_next = SEL_WIN;
    end else if (!wrapped && a >= 0 && a < POS_W'(HEAD)) begin
      sel_next = SEL_HEAD;
    end else begin
      sel_next = SEL_ZERO;
    end
  end

  always_comb begin
    ctl.clear   = (state == S_CHECK);
    ctl.pair_en = (state == S_PAIR);
    ctl.mul_en  = (state == S_MUL);
    ctl.acc_en  = (state == S_ACC);
  end

  sfd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WIN)) u_win (
    .clk(clk), .we(sample_acc), .waddr(wr_pos), .wdata(item.sample),
    .raddr(win_raddr), .rdata(win_rdata)
  );

  sfd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HEAD)) u_head (
    .clk(clk), .we(sample_acc && !wrapped && (seen < CNT_W'(HEAD))),
    .waddr(HEAD_AW'(seen)), .wdata(item.sample),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  sfd_mac u_mac (
    .clk(clk), .ctl(ctl),
    .ra1(raw[0]), .rb1(raw[1]), .ra2(raw[2]), .rb2(raw[3]),
    .refl1(refl1), .refl2(refl2),
    .use2(differentiate || !odd_length || (j != '0)),
    .sub(differentiate), .coef(coef_mem[ci]),
    .value(mac_value), .saturated(mac_sat)
  );

  // coefficient store
  always_ff @(posedge clk) begin
    if (accept && item.op == OP_COEF && (int'(item.coef_index) < MAX_TAPS)) begin
      coef_mem[TAP_AW'(item.coef_index)] <= item.coef_value;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      half_taps <= CFG_W'(1);
      odd_length <= 1'b1;
      differentiate <= 1'b0;
      edge_hold <= 1'b0;
      seen <= '0;
      done <= '0;
      wr_pos <= '0;
      wrapped <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HALF_TAPS:     half_taps <= cfg_data;
          CFG_ODD_LENGTH:    odd_length <= cfg_data[0];
          CFG_DIFFERENTIATE: differentiate <= cfg_data[0];
          CFG_EDGE_HOLD:     edge_hold <= cfg_data[0];
          default: ;
        endcase
      end
      // output word held until taken
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_acc) begin
            wr_pos <= (wr_pos == WIN_AW'(WIN - 1)) ? '0 : wr_pos + 1'b1;
            seen <= seen_next;
            if (seen_next == '0) begin
              wrapped <= 1'b1;
            end
            last_q <= item.last;
            pend <= seen_next - done;
            cnt <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (pend == '0 || cnt == RES_W'(MAX_RESULTS) ||
              (!last_q && (pend - 1'b1) < CNT_W'(look))) begin
            if (last_q) begin
              seen <= '0;
              done <= '0;
              wrapped <= 1'b0;
            end
            state <= S_IDLE;
          end else begin
            b <= pend - 1'b1;
            j <= '0;
            rd <= '0;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          sel <= sel_next;
          if (rd == 2'd0) begin
            refl1 <= refl;
          end
          if (rd == 2'd2) begin
            refl2 <= refl;
          end
          state <= S_WAIT;
        end
        S_WAIT: begin
          case (sel)
            SEL_WIN:  raw[rd] <= win_rdata;
            SEL_HEAD: raw[rd] <= head_rdata;
            default:  raw[rd] <= '0;
          endcase
          rd <= rd + 1'b1;
          state <= (rd == 2'd3) ? S_PAIR : S_ADDR;
        end
        S_PAIR: state <= S_MUL;
        S_MUL:  state <= S_ACC;
        S_ACC: begin
          if (CFG_W'(j) == n - 1'b1) begin
            state <= S_EMIT;
          end else begin
            j <= j + 1'b1;
            state <= S_ADDR;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result.value <= mac_value;
            result.saturated <= mac_sat;
            result.end_of_record <= last_q && (b == '0);
            done <= done + 1'b1;
            pend <= pend - 1'b1;
            cnt <= cnt + 1'b1;
            state <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= RES_W'(MAX_RESULTS) || state == S_IDLE)
    else $error("result count per word exceeded");
  a_wr_pos: assert property (@(posedge clk) disable iff (rst)
    wr_pos < WIN_AW'(WIN))
    else $error("window pointer out of range");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> (result_valid && state == S_CHECK))
    else $error("emit did not load the output register");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && $past(state) == S_IDLE) |-> $past(sample_acc))
    else $error("sequencer started without a sample word");
`endif

endmodule
`default_nettype wire

### verif/symmetric_fir_differentiator_checker.sv
`timescale 1ns / 100ps
module symmetric_fir_differentiator_checker
  import sfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             item_valid,
  input  wire logic             item_stall,
  input  item_t                 item,
  input  wire logic             result_valid,
  input  wire logic             result_stall,
  input  result_t               result,
  output int                    fail_count,
  output int                    outstanding
);

  // mirrored configuration
  logic [5:0] half_taps_r;
  logic       odd_r, diff_r, hold_r;

  // mirrored filter state
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] win_mem  [WIN];
  logic signed [SAMPLE_BITS-1:0] head_mem [HEAD];
  logic [15:0] seen_cnt, out_cnt;
  int          wptr;
  logic        wrapped_f;

  result_t expected_results[$];

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // sample at record position a, newest position s
  function automatic longint raw_sample(input longint s, input longint a);
    longint back;
    back = s - a;
    if (back >= 0 && back < WIN) return win_mem[(wptr + WIN - 1 - back) % WIN];
    if (a >= 0 && a < HEAD) return head_mem[a];
    return 0;
  endfunction

  // sample with edge extension beyond both ends of the record
  function automatic longint ext_sample(input longint s, input longint k);
    longint src;
    if (k > s) begin
      if (hold_r) return raw_sample(s, s);
      src = s - (k - s);
      if (src < 0) src = 0;
      return 2 * raw_sample(s, s) - raw_sample(s, src);
    end
    if (k < 0) begin
      if (hold_r) return raw_sample(s, 0);
      src = -k;
      if (src > s) src = s;
      return 2 * raw_sample(s, 0) - raw_sample(s, src);
    end
    return raw_sample(s, k);
  endfunction

  function automatic longint filter_out(input longint s, input longint p, input longint n);
    longint z;
    z = 0;
    if (diff_r) begin
      for (longint i = 1; i <= n; i++)
        z += longint'(coef_mem[n - i]) * (ext_sample(s, p + i) - ext_sample(s, p - i));
    end else if (odd_r) begin
      z = longint'(coef_mem[n - 1]) * ext_sample(s, p);
      for (longint i = 1; i < n; i++)
        z += longint'(coef_mem[n - 1 - i]) * (ext_sample(s, p + i) + ext_sample(s, p - i));
    end else begin
      for (longint i = 0; i < n; i++)
        z += longint'(coef_mem[n - 1 - i]) * (ext_sample(s, p - i) + ext_sample(s, p + i + 1));
    end
    return z >>> COEF_FRAC_BITS;
  endfunction

  // apply one accepted word and queue the outputs it releases
  task automatic predict_word(input item_t w);
    longint s, n, look, b, v;
    logic [15:0] pend;
    int cnt;
    result_t r;
    if (w.op == OP_COEF) begin
      coef_mem[w.coef_index] = w.coef_value;
    end else begin
      if (!wrapped_f && seen_cnt < HEAD) head_mem[seen_cnt] = w.sample;
      win_mem[wptr] = w.sample;
      wptr = (wptr + 1) % WIN;
      seen_cnt = seen_cnt + 16'd1;
      if (seen_cnt == 0) wrapped_f = 1'b1;
      s = wrapped_f ? longint'(seen_cnt) + 65535 : longint'(seen_cnt) - 1;
      n = (half_taps_r == 0) ? 1 : (half_taps_r > MAX_TAPS) ? MAX_TAPS : half_taps_r;
      look = (diff_r || !odd_r) ? n : n - 1;
      pend = seen_cnt - out_cnt;
      cnt = 0;
      while (pend > 0 && cnt < MAX_RESULTS) begin
        b = longint'(pend) - 1;
        if (!w.last && b < look) break;
        v = filter_out(s, s - b, n);
        r.saturated = 1'b0;
        if (v > 64'sd2147483647) begin
          v = 64'sd2147483647;
          r.saturated = 1'b1;
        end
        if (v < -64'sd2147483648) begin
          v = -64'sd2147483648;
          r.saturated = 1'b1;
        end
        r.value = v[31:0];
        r.end_of_record = w.last && b == 0;
        expected_results.push_back(r);
        cnt++;
        out_cnt = out_cnt + 16'd1;
        pend = pend - 16'd1;
      end
      if (w.last) begin
        seen_cnt = '0;
        out_cnt = '0;
        wrapped_f = 1'b0;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  // watch config, input and output channels
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      half_taps_r = 6'd1;
      odd_r = 1'b1;
      diff_r = 1'b0;
      hold_r = 1'b0;
      seen_cnt = '0;
      out_cnt = '0;
      wptr = 0;
      wrapped_f = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HALF_TAPS:     half_taps_r = cfg_data;
          CFG_ODD_LENGTH:    odd_r = cfg_data[0];
          CFG_DIFFERENTIATE: diff_r = cfg_data[0];
          CFG_EDGE_HOLD:     hold_r = cfg_data[0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) predict_word(item);
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected word value=%0d", result.value));
        end else begin
          e = expected_results.pop_front();
          if (result.value !== e.value)
            flag_mismatch($sformatf("value %0d, want %0d", result.value, e.value));
          if (result.saturated !== e.saturated)
            flag_mismatch($sformatf("saturated %b, want %b", result.saturated, e.saturated));
          if (result.end_of_record !== e.end_of_record)
            flag_mismatch($sformatf("end_of_record %b, want %b",
                                    result.end_of_record, e.end_of_record));
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

### verif/symmetric_fir_differentiator_test.sv
`timescale 1ns / 100ps
module symmetric_fir_differentiator_test;
  import sfd_pkg::*;

  localparam int IDLE_LIMIT = 60000;
  localparam int SETTLE     = 450;
  localparam int ITEM_GOAL  = 410;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = CFG_HALF_TAPS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             item_valid = 1'b0;
  logic             item_stall;
  item_t            item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  int               fail_count, outstanding;
  int               words_sent = 0;
  int               burst_left = 0;
  int               idle_cycles = 0;
  logic             squeeze = 1'b0;
  int               cur_taps = 1;

  always #10 clk = ~clk;

  symmetric_fir_differentiator u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .item_valid, .item_stall, .item,
    .result_valid, .result_stall, .result
  );

  symmetric_fir_differentiator_checker u_check (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .item_valid, .item_stall, .item,
    .result_valid, .result_stall, .result,
    .fail_count, .outstanding
  );

  // watchdog on cycles without any accepted word or taken result
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode, span;
    @(negedge clk);
    forever begin
      if (squeeze) begin
        result_stall = 1'b1;
        repeat (1500) @(negedge clk);
        squeeze = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        case (mode)
          0: result_stall = 1'b0;
          1: result_stall = ($urandom_range(0, 3) == 0);
          2: result_stall = ~result_stall;
          default: result_stall = ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // present one word in bursts with random gaps; returns at a falling edge
  task automatic send_word(input item_t w);
    int gap;
    if (burst_left == 0) begin
      item_valid = 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item = w;
    item_valid = 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    item_valid = 1'b0;
    words_sent++;
  endtask

  task automatic send_coef(input logic [4:0] slot, input logic [23:0] val);
    item_t w;
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    w = junk[$bits(item_t)-1:0];
    w.op = OP_COEF;
    w.coef_index = slot;
    w.coef_value = val;
    send_word(w);
  endtask

  task automatic send_sample(input logic [15:0] x, input logic fin);
    item_t w;
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    w = junk[$bits(item_t)-1:0];
    w.op = OP_SAMPLE;
    w.sample = x;
    w.last = fin;
    send_word(w);
  endtask

  // one record of random content, with a few coefficient words mixed in
  task automatic send_record(input int len);
    logic [15:0] x;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_coef(5'($urandom), 24'($urandom));
      case ($urandom_range(0, 7))
        0: x = 16'h7FFF;
        1: x = 16'h8000;
        2: x = 16'($signed($urandom_range(0, 200)) - 100);
        default: x = 16'($urandom);
      endcase
      send_sample(x, i == len - 1);
    end
  endtask

  // registers change only with the block drained
  task automatic set_config(input logic [5:0] taps, input logic odd, input logic diff,
                            input logic hold);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_HALF_TAPS;
    cfg_data = taps;
    @(negedge clk);
    cfg_index = CFG_ODD_LENGTH;
    cfg_data = {5'($urandom_range(0, 31)), odd};
    @(negedge clk);
    cfg_index = CFG_DIFFERENTIATE;
    cfg_data = {5'($urandom_range(0, 31)), diff};
    @(negedge clk);
    cfg_index = CFG_EDGE_HOLD;
    cfg_data = {5'($urandom_range(0, 31)), hold};
    @(negedge clk);
    cfg_we = 1'b0;
    cur_taps = (taps == 0) ? 1 : (taps > MAX_TAPS) ? MAX_TAPS : taps;
  endtask

  function automatic int record_len();
    if ($urandom_range(0, 4) == 0) return $urandom_range(1, cur_taps + 1);
    return cur_taps + $urandom_range(2, (cur_taps > 8) ? 12 : 30);
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the whole coefficient store, extremes first
    send_coef(5'd0, 24'h7FFFFF);
    send_coef(5'd1, 24'h800000);
    send_coef(5'd2, 24'h000000);
    for (int i = 3; i < MAX_TAPS; i++) send_coef(i[4:0], 24'($urandom));

    // reset settings: single-sample record, then sample extremes
    send_sample(16'h1234, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h7FFF, 1'b1);

    // extreme settings, including out-of-range tap counts
    set_config(6'd32, 1'b1, 1'b0, 1'b0);
    send_record(36);
    set_config(6'd32, 1'b0, 1'b0, 1'b1);
    send_record(5);
    set_config(6'd32, 1'b1, 1'b1, 1'b0);
    send_record(34);
    set_config(6'd1, 1'b0, 1'b0, 1'b1);
    send_record(4);
    set_config(6'd1, 1'b0, 1'b1, 1'b1);
    send_record(3);
    set_config(6'd0, 1'b1, 1'b0, 1'b0);
    send_record(3);
    set_config(6'd63, 1'b0, 1'b1, 1'b0);
    send_record(2);

    // long receiver hold-off while the sender keeps offering words
    set_config(6'd2, 1'b1, 1'b0, 1'b0);
    squeeze = 1'b1;
    burst_left = 1000;
    send_record(50);

    // random settings, mostly small tap counts
    while (words_sent < ITEM_GOAL) begin
      set_config(($urandom_range(0, 5) == 0) ? 6'($urandom_range(17, 32))
                                             : 6'($urandom_range(1, 8)),
                 1'($urandom), 1'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 3)) send_record(record_len());
    end

    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
